>>> rtl/core/isotp_pkg.sv
// Shared types and codes of the ISO-TP receive reassembler.
// Depends on nothing; every other file in rtl/core depends on it.
`default_nettype none

package isotp_pkg;

  // Field widths
  localparam int unsigned IdW   = 29;
  localparam int unsigned LenW  = 12;
  localparam int unsigned IdleW = 16;

  // Command codes of an input word
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_FRAME = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_FLOWCTL = 2'd2;
  localparam logic [1:0] KIND_REQUEST = 2'd3;

  // Error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_UNEXP    = 3'd1;
  localparam logic [2:0] ERR_BAD_DLC  = 3'd2;
  localparam logic [2:0] ERR_REP_FF   = 3'd3;
  localparam logic [2:0] ERR_CF_NO_FF = 3'd4;
  localparam logic [2:0] ERR_BAD_PCI  = 3'd5;
  localparam logic [2:0] ERR_TIMEOUT  = 3'd6;

  // PCI types (high nibble of byte 0)
  localparam logic [3:0] PCI_SF = 4'h0;
  localparam logic [3:0] PCI_FF = 4'h1;
  localparam logic [3:0] PCI_CF = 4'h2;

  // Configuration register indexes
  localparam logic [1:0] REG_REQUEST_ID = 2'd0;
  localparam logic [1:0] REG_FC_BS      = 2'd1;
  localparam logic [1:0] REG_FC_STMIN   = 2'd2;
  localparam logic [1:0] REG_TIMEOUT    = 2'd3;

  // Protocol constants
  localparam logic [7:0] FC_PCI_BYTE  = 8'h30;
  localparam logic [7:0] REQ_PCI_BYTE = 8'h02;
  localparam logic [3:0] DLC_FULL     = 4'd8;
  localparam logic [2:0] SF_MAX_LEN   = 3'd7;
  localparam logic [2:0] FF_PAY_BYTES = 3'd6;
  localparam logic [2:0] CF_PAY_BYTES = 3'd7;

  // Register reset values
  localparam logic [IdW-1:0]   REQUEST_ID_RST = 29'd2015;
  localparam logic [IdleW-1:0] TIMEOUT_RST    = 16'd100;

  typedef struct packed {
    logic [1:0]     command;
    logic [15:0]    service_pid;
    logic [IdW-1:0] frame_id_in;
    logic [3:0]     frame_length;
    logic [7:0]     rx_byte0;
    logic [7:0]     rx_byte1;
    logic [7:0]     rx_byte2;
    logic [7:0]     rx_byte3;
    logic [7:0]     rx_byte4;
    logic [7:0]     rx_byte5;
    logic [7:0]     rx_byte6;
    logic [7:0]     rx_byte7;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [IdW-1:0]  tx_frame_id;
    logic [7:0]      tx_byte0;
    logic [7:0]      tx_byte1;
    logic [7:0]      tx_byte2;
    logic [7:0]      data_byte;
    logic [LenW-1:0] data_index;
    logic [LenW-1:0] total_length;
    logic [2:0]      error_code;
    logic            complete;
    logic            last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]     index;
    logic [IdW-1:0] value;
  } cfg_wr_t;

  typedef struct packed {
    logic [IdW-1:0]   request_can_id;
    logic [7:0]       fc_block_size;
    logic [7:0]       fc_separation_time;
    logic [IdleW-1:0] timeout_ticks;
  } cfg_regs_t;

  typedef struct packed {
    logic             open;
    logic             ff_seen;
    logic [LenW-1:0]  expected_length;
    logic [LenW-1:0]  received_count;
    logic [IdW-1:0]   fc_target_id;
    logic [IdleW-1:0] idle_ticks;
  } sess_t;

  // Work for one word: n_pay payload results, then an optional tail result
  typedef struct packed {
    logic [6:0][7:0] bytes;
    logic [2:0]      n_pay;
    logic [LenW-1:0] start_index;
    logic            has_tail;
    logic [1:0]      tail_kind;
    logic [IdW-1:0]  tail_id;
    logic [7:0]      tail_b0;
    logic [7:0]      tail_b1;
    logic [7:0]      tail_b2;
    logic [2:0]      tail_err;
    logic [LenW-1:0] total;
    logic            complete;
  } job_t;

endpackage

`default_nettype wire

>>> rtl/core/isotp_if.sv
// Handshake interfaces for the input, result and configuration words.
// Depends on isotp_pkg for the payload types.
`default_nettype none

interface isotp_item_if;
  logic               valid;
  logic               ready;
  isotp_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface isotp_result_if;
  logic                 valid;
  logic                 ready;
  isotp_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface isotp_cfg_if;
  logic               valid;
  logic               ready;
  isotp_pkg::cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/isotp_frame_plan.sv
// Decodes one input word against the session state: next session state
// and the list of results to emit. Combinational; depends on isotp_pkg.
`default_nettype none

module isotp_frame_plan (
  input  isotp_pkg::in_item_t  item_i,
  input  isotp_pkg::sess_t     sess_i,
  input  isotp_pkg::cfg_regs_t cfg_i,
  output isotp_pkg::sess_t     sess_o,
  output isotp_pkg::job_t      job_o,
  output logic                 emit_o
);
  import isotp_pkg::*;

  logic [3:0]       pci;
  logic [3:0]       nib;
  logic [6:0][7:0]  cf_bytes;
  logic [6:0][7:0]  ff_bytes;
  logic [LenW-1:0]  cf_avail;
  logic [LenW-1:0]  ff_len;
  logic [LenW-1:0]  ff_avail;
  logic [2:0]       sf_n;
  logic [2:0]       cf_n;
  logic [2:0]       ff_n;
  logic [LenW-1:0]  cf_rc_new;
  logic [LenW-1:0]  ff_rc_new;
  logic [IdleW-1:0] idle_inc;
  logic             cf_done;
  logic             ff_done;

  assign pci = item_i.rx_byte0[7:4];
  assign nib = item_i.rx_byte0[3:0];

  // Payload byte lanes: single and consecutive frames start at byte 1,
  // first frames at byte 2
  assign cf_bytes = {item_i.rx_byte7, item_i.rx_byte6, item_i.rx_byte5, item_i.rx_byte4,
                     item_i.rx_byte3, item_i.rx_byte2, item_i.rx_byte1};
  assign ff_bytes = {8'h00, item_i.rx_byte7, item_i.rx_byte6, item_i.rx_byte5,
                     item_i.rx_byte4, item_i.rx_byte3, item_i.rx_byte2};

  // Clip byte counts to what remains of the message
  assign sf_n      = (nib > 4'(SF_MAX_LEN)) ? SF_MAX_LEN : nib[2:0];
  assign cf_avail  = (sess_i.expected_length > sess_i.received_count) ?
                     (sess_i.expected_length - sess_i.received_count) : '0;
  assign cf_n      = (cf_avail > LenW'(CF_PAY_BYTES)) ? CF_PAY_BYTES : cf_avail[2:0];
  assign cf_rc_new = sess_i.received_count + LenW'(cf_n);
  assign cf_done   = (cf_rc_new >= sess_i.expected_length);

  assign ff_len    = {nib, item_i.rx_byte1};
  assign ff_avail  = (ff_len > sess_i.received_count) ? (ff_len - sess_i.received_count) : '0;
  assign ff_n      = (ff_avail > LenW'(FF_PAY_BYTES)) ? FF_PAY_BYTES : ff_avail[2:0];
  assign ff_rc_new = sess_i.received_count + LenW'(ff_n);
  assign ff_done   = (ff_rc_new >= ff_len);

  // Saturating idle counter
  assign idle_inc = (sess_i.idle_ticks == '1) ? sess_i.idle_ticks : (sess_i.idle_ticks + 1'b1);

  // Work out next state and the result list
  always_comb begin
    sess_o             = sess_i;
    emit_o             = 1'b0;
    job_o              = '0;
    job_o.total        = sess_i.expected_length;
    job_o.has_tail     = 1'b1;
    job_o.tail_kind    = KIND_STATUS;
    job_o.tail_err     = ERR_NONE;

    unique case (item_i.command)
      CMD_START: begin
        sess_o.open            = 1'b1;
        sess_o.ff_seen         = 1'b0;
        sess_o.expected_length = '0;
        sess_o.received_count  = '0;
        sess_o.fc_target_id    = cfg_i.request_can_id;
        sess_o.idle_ticks      = '0;
        emit_o                 = 1'b1;
        job_o.total            = '0;
        job_o.tail_kind        = KIND_REQUEST;
        job_o.tail_id          = cfg_i.request_can_id;
        job_o.tail_b0          = REQ_PCI_BYTE;
        job_o.tail_b1          = item_i.service_pid[15:8];
        job_o.tail_b2          = item_i.service_pid[7:0];
      end
      CMD_FRAME: begin
        sess_o.idle_ticks = '0;
        emit_o            = 1'b1;
        if (!sess_i.open) begin
          job_o.tail_err = ERR_UNEXP;
        end else if (item_i.frame_length != DLC_FULL) begin
          job_o.tail_err = ERR_BAD_DLC;
        end else begin
          case (pci)
            PCI_SF: begin
              sess_o.expected_length = LenW'(sf_n);
              sess_o.received_count  = LenW'(sf_n);
              sess_o.open            = 1'b0;
              job_o.total            = LenW'(sf_n);
              job_o.bytes            = cf_bytes;
              job_o.n_pay            = sf_n;
              job_o.start_index      = '0;
              job_o.has_tail         = (sf_n == 3'd0);
              job_o.complete         = 1'b1;
            end
            PCI_FF: begin
              if (sess_i.ff_seen) begin
                job_o.tail_err = ERR_REP_FF;
              end else begin
                sess_o.expected_length = ff_len;
                sess_o.received_count  = ff_rc_new;
                sess_o.fc_target_id    = item_i.frame_id_in;
                sess_o.ff_seen         = 1'b1;
                sess_o.open            = !ff_done;
                job_o.total            = ff_len;
                job_o.bytes            = ff_bytes;
                job_o.n_pay            = ff_n;
                job_o.start_index      = sess_i.received_count;
                job_o.tail_kind        = KIND_FLOWCTL;
                job_o.tail_id          = item_i.frame_id_in;
                job_o.tail_b0          = FC_PCI_BYTE;
                job_o.tail_b1          = cfg_i.fc_block_size;
                job_o.tail_b2          = cfg_i.fc_separation_time;
                job_o.complete         = ff_done;
              end
            end
            PCI_CF: begin
              if (!sess_i.ff_seen) begin
                job_o.tail_err = ERR_CF_NO_FF;
              end else begin
                sess_o.received_count = cf_rc_new;
                sess_o.open           = !cf_done;
                job_o.bytes           = cf_bytes;
                job_o.n_pay           = cf_n;
                job_o.start_index     = sess_i.received_count;
                job_o.has_tail        = (cf_n == 3'd0);
                job_o.complete        = cf_done;
              end
            end
            default: begin
              job_o.tail_err = ERR_BAD_PCI;
            end
          endcase
        end
      end
      CMD_TICK: begin
        if (sess_i.open) begin
          sess_o.idle_ticks = idle_inc;
          if (idle_inc >= cfg_i.timeout_ticks) begin
            sess_o.open    = 1'b0;
            emit_o         = 1'b1;
            job_o.tail_err = ERR_TIMEOUT;
          end
        end
      end
      default: begin
        emit_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/isotp_receive_reassembler.sv
// Top level of the ISO-TP receive reassembler: session registers, config
// registers, job register, result emitter. Depends on isotp_pkg, isotp_if
// and isotp_frame_plan.
//
//   channel   dir  modport  word
//   item_i    in   sink     command, frame fields, data bytes
//   result_o  out  source   one result (status, payload byte, FC or request)
//   cfg_i     in   sink     register index and value, always ready
//
// Each accepted word is decoded in the cycle it is taken and parked in the
// job register; the emitter then loads one result per cycle into the output
// register while the output is not stalled. A word gives 1 to 7 results, or
// none. The next word is taken in the cycle the last result of the current
// one is loaded. Reset clears session state and sets the config registers to
// their defaults. A stalled output holds the output register and, behind it,
// the job register.
`default_nettype none

module isotp_receive_reassembler (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  isotp_item_if.sink            item_i,
  isotp_result_if.source        result_o,
  isotp_cfg_if.sink             cfg_i
);
  import isotp_pkg::*;

  cfg_regs_t cfg_q;
  sess_t     sess_q, sess_d;
  job_t      job_q, job_d;
  logic      job_valid_q, job_valid_d;
  logic [2:0] pos_q, pos_d;
  logic      plan_emit;
  out_item_t out_q, res;
  logic      out_valid_q, out_valid_d;
  logic      is_pay;
  logic      res_last;
  logic      out_load;
  logic      accept;

  // Decode the incoming word
  isotp_frame_plan u_plan (
    .item_i (item_i.data),
    .sess_i (sess_q),
    .cfg_i  (cfg_q),
    .sess_o (sess_d),
    .job_o  (job_d),
    .emit_o (plan_emit)
  );

  // Config writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.request_can_id     <= REQUEST_ID_RST;
      cfg_q.fc_block_size      <= '0;
      cfg_q.fc_separation_time <= '0;
      cfg_q.timeout_ticks      <= TIMEOUT_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        REG_REQUEST_ID: cfg_q.request_can_id     <= cfg_i.data.value;
        REG_FC_BS:      cfg_q.fc_block_size      <= cfg_i.data.value[7:0];
        REG_FC_STMIN:   cfg_q.fc_separation_time <= cfg_i.data.value[7:0];
        REG_TIMEOUT:    cfg_q.timeout_ticks      <= cfg_i.data.value[IdleW-1:0];
        default:        cfg_q                    <= cfg_q;
      endcase
    end
  end

  // Build the result at the current emitter position
  assign is_pay = (pos_q < job_q.n_pay);

  always_comb begin
    res              = '0;
    res.total_length = job_q.total;
    if (is_pay) begin
      res_last       = (3'(pos_q + 3'd1) == job_q.n_pay) && !job_q.has_tail;
      res.kind       = KIND_PAYLOAD;
      res.data_byte  = job_q.bytes[pos_q];
      res.data_index = job_q.start_index + LenW'(pos_q);
      res.error_code = ERR_NONE;
    end else begin
      res_last        = 1'b1;
      res.kind        = job_q.tail_kind;
      res.tx_frame_id = job_q.tail_id;
      res.tx_byte0    = job_q.tail_b0;
      res.tx_byte1    = job_q.tail_b1;
      res.tx_byte2    = job_q.tail_b2;
      res.error_code  = job_q.tail_err;
    end
    res.complete = job_q.complete & res_last;
    res.last     = res_last;
  end

  // Handshakes
  assign out_load     = job_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !job_valid_q || (out_load && res_last);
  assign accept       = item_i.valid && item_i.ready;

  // Advance the job and the emitter position
  always_comb begin
    job_valid_d = job_valid_q;
    pos_d       = pos_q;
    if (out_load) begin
      pos_d = 3'(pos_q + 3'd1);
      if (res_last) begin
        job_valid_d = 1'b0;
      end
    end
    if (accept) begin
      job_valid_d = plan_emit;
      pos_d       = '0;
    end
  end

  assign out_valid_d = out_load || (out_valid_q && !result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sess_q      <= '0;
      job_valid_q <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        sess_q <= sess_d;
      end
      job_valid_q <= job_valid_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q <= job_d;
    end
    if (out_load) begin
      out_q <= res;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

endmodule

`default_nettype wire
